// File: sv/modbus_rtu_median_sensor_responder_unit_defines.svh
// Assertion macros for the Modbus RTU median responder
`ifndef MODBUS_RTU_MEDIAN_SENSOR_RESPONDER_UNIT_DEFINES_SVH
`define MODBUS_RTU_MEDIAN_SENSOR_RESPONDER_UNIT_DEFINES_SVH
// assert that a implies b on the same edge
`define MRM_ASSERT_IMP(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
      else $error("assertion failed");
// assert that a implies b on the next edge
`define MRM_ASSERT_NEXT(label, clk, rst, a, b) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
      else $error("assertion failed");
`endif

// File: sv/mrm_pkg.sv
// ----------------------------------------------------------------------------
// mrm_pkg
// Shared constants and functions of the Modbus RTU median responder.
// ----------------------------------------------------------------------------
package mrm_pkg;
   localparam int WINDOW_DEF      = 9;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam logic [7:0]  ADDR_RESET = 8'h0B;
   localparam logic [7:0]  REG_RESET  = 8'h01;
   localparam logic [3:0]  SKIP_RESET = 4'd7;
   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;
   localparam logic [7:0]  FUNC_READ  = 8'h04;
   localparam logic [7:0]  BYTE_CNT   = 8'h02;
   localparam logic [1:0]  REG_ADDR   = 2'd0;
   localparam logic [1:0]  REG_TARGET = 2'd1;
   localparam logic [1:0]  REG_SKIP   = 2'd2;

   function automatic logic [7:0] err_char(input logic [3:0] i);
      logic [127:0] txt;
      txt = "Wrong address!!!";
      return txt[8*(15-i) +: 8];
   endfunction

   // one bit step of reflected CRC-16
   function automatic logic [15:0] crc_bit(input logic [15:0] c);
      return c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
   endfunction
endpackage

// File: sv/mrm_median.sv
// ----------------------------------------------------------------------------
// mrm_median
// Sample window and iterative median select: one compare unit, rank counting.
// For each candidate i the unit counts entries that sort ahead of it; the
// candidate whose rank range holds WINDOW/2 is the median.
// ----------------------------------------------------------------------------
module mrm_median #(
   parameter int WINDOW      = 9,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [SAMPLE_BITS-1:0] wr_data,
   input  logic                   start,
   output logic                   done,
   output logic [15:0]            median
);
   import mrm_pkg::*;
   localparam int IW = $clog2(WINDOW);
   localparam int CW = $clog2(WINDOW + 1);
   localparam logic [CW-1:0] MID = CW'(WINDOW / 2);
   localparam logic [IW-1:0] LAST = IW'(WINDOW - 1);

   logic [SAMPLE_BITS-1:0] win_ff [WINDOW];
   logic [IW-1:0] slot_ff, slot_in;
   logic [IW-1:0] i_ff, i_in, j_ff, j_in;
   logic [CW-1:0] gt_ff, gt_in, eq_ff, eq_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [15:0] med_ff, med_in;
   logic [SAMPLE_BITS-1:0] vi, vj;

   assign vi = win_ff[i_ff];
   assign vj = win_ff[j_ff];

   always_comb begin
      slot_in = slot_ff;
      if (wr_en) slot_in = (slot_ff == LAST) ? '0 : slot_ff + 1'b1;
      i_in = i_ff; j_in = j_ff; gt_in = gt_ff; eq_in = eq_ff;
      busy_in = busy_ff; done_in = 1'b0; med_in = med_ff;
      if (start) begin
         busy_in = 1'b1; i_in = '0; j_in = '0; gt_in = '0; eq_in = '0;
      end else if (busy_ff) begin
         // count greater and earlier-equal entries
         if (vj > vi) gt_in = gt_ff + 1'b1;
         else if (vj == vi && j_ff < i_ff) eq_in = eq_ff + 1'b1;
         if (j_ff == LAST) begin
            if (gt_in + eq_in == MID) begin
               med_in = 16'(vi); busy_in = 1'b0; done_in = 1'b1;
            end else begin
               i_in = i_ff + 1'b1; j_in = '0; gt_in = '0; eq_in = '0;
            end
         end else begin
            j_in = j_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0; busy_ff <= 1'b0; done_ff <= 1'b0;
         for (int k = 0; k < WINDOW; k++) win_ff[k] <= '0;
      end else begin
         slot_ff <= slot_in; busy_ff <= busy_in; done_ff <= done_in;
         if (wr_en) win_ff[slot_ff] <= wr_data;
      end
      i_ff <= i_in; j_ff <= j_in; gt_ff <= gt_in; eq_ff <= eq_in; med_ff <= med_in;
   end

   assign done = done_ff;
   assign median = med_ff;
endmodule

// File: sv/modbus_rtu_median_sensor_responder_unit.sv
// ----------------------------------------------------------------------------
// modbus_rtu_median_sensor_responder_unit
// Modbus RTU slave answering read-input-register with a window median.
// ----------------------------------------------------------------------------
//  channel | direction | fields
//  req_    | in        | cmd, bus_byte, sample
//  rsp_    | out       | out_byte, last_byte, is_error_text
//  csr_    | APB       | own_address, target_register, skip_count
// Frame bytes 0 to 5 are accepted, then folded into the CRC one bit a cycle; a
// sample, a discarded byte or frame byte 6 needs no CRC step. Frame byte 7 leads
// to a check; a good frame then runs the median select and the response CRC over
// 5 bytes, then one output byte per cycle while rsp_stall is low.
// Reset is synchronous; the window clears to zero at once.
// req_stall is high while an item is at work or results are pending.
`include "modbus_rtu_median_sensor_responder_unit_defines.svh"
module modbus_rtu_median_sensor_responder_unit #(
   parameter int WINDOW      = mrm_pkg::WINDOW_DEF,
   parameter int SAMPLE_BITS = mrm_pkg::SAMPLE_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_bus_byte,
   input  logic [15:0] req_sample,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last_byte,
   output logic        rsp_is_error_text,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import mrm_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001, ST_CRC  = 7'b0000010, ST_MED = 7'b0000100,
      ST_RCRC = 7'b0001000, ST_RSP  = 7'b0010000, ST_ERR = 7'b0100000,
      ST_CHK  = 7'b1000000
   } state_type;
   typedef enum logic [1:0] {PH_IDLE = 2'd0, PH_FRAME = 2'd1, PH_DISC = 2'd2} phase_type;

   logic [7:0] addr_ff, tgt_ff; logic [3:0] skip_ff;
   state_type st_ff, st_in;
   phase_type ph_ff, ph_in;
   logic [2:0] cnt_ff, cnt_in;
   logic [7:0] frame_ff [8];
   logic [15:0] crc_ff, crc_in;
   logic [3:0] disc_ff, disc_in;
   logic [2:0] bit_ff, bit_in;
   logic [3:0] oi_ff, oi_in;
   logic [7:0] rsp_byte [7];
   logic [15:0] rcrc_ff, rcrc_in, med;
   logic acc, wr, med_start, med_done, fr_we, rv_ff, rv_in, orsp_take;
   logic [2:0] fr_idx;
   logic [7:0] ob;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;
   assign acc = req_valid && !req_stall;
   assign req_stall = (st_ff != ST_IDLE) || rv_ff;
   assign orsp_take = rv_ff && !rsp_stall;

   always_comb begin
      unique case (paddr[3:2])
         REG_ADDR:   prdata = {24'd0, addr_ff};
         REG_TARGET: prdata = {24'd0, tgt_ff};
         REG_SKIP:   prdata = {28'd0, skip_ff};
         default:    prdata = '0;
      endcase
   end

   mrm_median #(.WINDOW(WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_med (
      .clock(clock), .reset(reset), .wr_en(acc && req_cmd),
      .wr_data(req_sample[SAMPLE_BITS-1:0]), .start(med_start),
      .done(med_done), .median(med)
   );

   assign rsp_byte[0] = frame_ff[0];
   assign rsp_byte[1] = FUNC_READ;
   assign rsp_byte[2] = BYTE_CNT;
   assign rsp_byte[3] = med[15:8];
   assign rsp_byte[4] = med[7:0];
   assign rsp_byte[5] = rcrc_ff[7:0];
   assign rsp_byte[6] = rcrc_ff[15:8];

   always_comb begin
      st_in = st_ff; ph_in = ph_ff; cnt_in = cnt_ff; crc_in = crc_ff;
      disc_in = disc_ff; bit_in = bit_ff; oi_in = oi_ff; rcrc_in = rcrc_ff;
      rv_in = rv_ff; med_start = 1'b0; fr_we = 1'b0; fr_idx = cnt_ff;
      if (orsp_take) rv_in = 1'b0;
      unique case (st_ff)
         ST_IDLE: if (acc && !req_cmd) begin
            unique case (ph_ff)
               PH_DISC: begin
                  disc_in = (disc_ff != 0) ? disc_ff - 1'b1 : disc_ff;
                  if (disc_in == 0) ph_in = PH_IDLE;
               end
               PH_FRAME: begin
                  fr_we = 1'b1;
                  if (cnt_ff <= 3'd5) begin
                     crc_in = crc_ff ^ {8'd0, req_bus_byte}; bit_in = '0; st_in = ST_CRC;
                  end
                  if (cnt_ff == 3'd7) st_in = ST_CHK;
                  else cnt_in = cnt_ff + 1'b1;
               end
               default: begin
                  if (req_bus_byte == addr_ff) begin
                     fr_we = 1'b1; fr_idx = '0;
                     crc_in = CRC_INIT ^ {8'd0, req_bus_byte}; bit_in = '0;
                     cnt_in = 3'd1; ph_in = PH_FRAME; st_in = ST_CRC;
                  end else begin
                     disc_in = skip_ff; ph_in = (skip_ff != 0) ? PH_DISC : PH_IDLE;
                     oi_in = '0; st_in = ST_ERR;
                  end
               end
            endcase
         end
         ST_CRC: begin
            crc_in = crc_bit(crc_ff); bit_in = bit_ff + 1'b1;
            if (bit_ff == 3'd7) st_in = ST_IDLE;
         end
         ST_CHK: begin
            ph_in = PH_IDLE; cnt_in = '0; crc_in = CRC_INIT; st_in = ST_IDLE;
            if (crc_ff[7:0] == frame_ff[6] && crc_ff[15:8] == frame_ff[7]
                && frame_ff[3] == tgt_ff) begin
               med_start = 1'b1; st_in = ST_MED;
            end
         end
         ST_MED: if (med_done) begin
            oi_in = '0; bit_in = '0; rcrc_in = CRC_INIT ^ {8'd0, rsp_byte[0]};
            st_in = ST_RCRC;
         end
         ST_RCRC: begin
            rcrc_in = crc_bit(rcrc_ff); bit_in = bit_ff + 1'b1;
            if (bit_ff == 3'd7) begin
               if (oi_ff == 4'd4) begin oi_in = '0; st_in = ST_RSP; end
               else begin
                  oi_in = oi_ff + 1'b1;
                  rcrc_in = crc_bit(rcrc_ff) ^ {8'd0, rsp_byte[oi_ff[2:0] + 3'd1]};
               end
            end
         end
         ST_RSP, ST_ERR: if (!rv_ff || orsp_take) begin
            rv_in = 1'b1; oi_in = oi_ff + 1'b1;
            if ((st_ff == ST_RSP && oi_ff == 4'd6) || (st_ff == ST_ERR && oi_ff == 4'd15))
               st_in = ST_IDLE;
         end
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff <= ADDR_RESET; tgt_ff <= REG_RESET; skip_ff <= SKIP_RESET;
         st_ff <= ST_IDLE; ph_ff <= PH_IDLE; cnt_ff <= '0; crc_ff <= CRC_INIT;
         disc_ff <= '0; rv_ff <= 1'b0;
      end else begin
         if (wr) begin
            unique case (paddr[3:2])
               REG_ADDR:   addr_ff <= pwdata[7:0];
               REG_TARGET: tgt_ff <= pwdata[7:0];
               REG_SKIP:   skip_ff <= pwdata[3:0];
               default:    ;
            endcase
         end
         st_ff <= st_in; ph_ff <= ph_in; cnt_ff <= cnt_in; crc_ff <= crc_in;
         disc_ff <= disc_in; rv_ff <= rv_in;
      end
      if (fr_we) frame_ff[fr_idx] <= req_bus_byte;
      bit_ff <= bit_in; oi_ff <= oi_in; rcrc_ff <= rcrc_in;
      if ((st_ff == ST_RSP || st_ff == ST_ERR) && (!rv_ff || orsp_take)) begin
         rsp_out_byte <= ob;
         rsp_last_byte <= (st_in == ST_IDLE);
         rsp_is_error_text <= (st_ff == ST_ERR);
      end
   end

   assign ob = (st_ff == ST_ERR) ? err_char(oi_ff) : rsp_byte[oi_ff[2:0]];
   assign rsp_valid = rv_ff;

   `MRM_ASSERT_IMP(a_no_accept_busy, clock, reset, st_ff != ST_IDLE, req_stall)
   `MRM_ASSERT_NEXT(a_hold_out, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `MRM_ASSERT_IMP(a_rsp_state, clock, reset, st_ff == ST_MED, ph_ff == PH_IDLE)
endmodule

// File: tb/modbus_rtu_median_sensor_responder_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_median_sensor_responder_unit_checker
// Watches the request and response channels, predicts the transmitted bytes
// of the Modbus responder and compares them byte by byte in order.
// ----------------------------------------------------------------------------
module modbus_rtu_median_sensor_responder_unit_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_bus_byte,
   input  logic [15:0] req_sample,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_out_byte,
   input  logic        rsp_last_byte,
   input  logic        rsp_is_error_text,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   input  logic        pready,
   output int          fail_count,
   output int          pending
);
   import mrm_pkg::*;

   typedef enum logic [2:0] {
      HUNT = 3'b001, COLLECT = 3'b010, DISCARD = 3'b100
   } link_phase_type;
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       err;
   } tx_byte_type;

   localparam logic [127:0] ERR_TEXT = "Wrong address!!!";

   tx_byte_type    tx_queue[$];
   logic [7:0]     my_addr, my_reg;
   logic [3:0]     my_skip, skip_left;
   link_phase_type ph;
   logic [2:0]     nbytes;
   logic [7:0]     frame[8];
   logic [15:0]    crc;
   logic [15:0]    window[WINDOW_DEF];
   int             slot;

   function automatic logic [15:0] crc16(input logic [15:0] c, input logic [7:0] b);
      c = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      return c;
   endfunction

   function automatic logic [15:0] window_median();
      logic [15:0] s[WINDOW_DEF];
      logic [15:0] t;
      s = window;
      for (int i = 0; i < WINDOW_DEF - 1; i++)
         for (int j = i + 1; j < WINDOW_DEF; j++)
            if (s[i] < s[j]) begin
               t = s[i]; s[i] = s[j]; s[j] = t;
            end
      return s[WINDOW_DEF / 2];
   endfunction

   task automatic push(input logic [7:0] d, input logic l, input logic e);
      tx_byte_type x;
      x.data = d; x.last = l; x.err = e;
      tx_queue.push_back(x);
   endtask

   task automatic take_item(input logic c, input logic [7:0] b, input logic [15:0] smp);
      logic [7:0]  r[7];
      logic [15:0] m, rc;
      if (c) begin
         window[slot] = smp;
         slot = (slot + 1) % WINDOW_DEF;
         return;
      end
      unique case (ph)
         DISCARD: begin
            if (skip_left > 0) skip_left--;
            if (skip_left == 0) ph = HUNT;
         end
         COLLECT: begin
            frame[nbytes] = b;
            if (nbytes <= 5) crc = crc16(crc, b);
            if (nbytes < 7) begin
               nbytes++;
            end else begin
               ph = HUNT;
               nbytes = 0;
               if (crc[7:0] == frame[6] && crc[15:8] == frame[7] && frame[3] == my_reg) begin
                  m = window_median();
                  r[0] = frame[0]; r[1] = FUNC_READ; r[2] = BYTE_CNT;
                  r[3] = m[15:8]; r[4] = m[7:0];
                  rc = 16'hFFFF;
                  for (int i = 0; i < 5; i++) rc = crc16(rc, r[i]);
                  r[5] = rc[7:0]; r[6] = rc[15:8];
                  for (int i = 0; i < 7; i++) push(r[i], i == 6, 1'b0);
               end
               crc = 16'hFFFF;
            end
         end
         default: begin
            if (b == my_addr) begin
               frame[0] = b;
               crc = crc16(16'hFFFF, b);
               nbytes = 1;
               ph = COLLECT;
            end else begin
               for (int i = 0; i < 16; i++) push(ERR_TEXT[8*(15-i) +: 8], i == 15, 1'b1);
               skip_left = my_skip;
               ph = (my_skip > 0) ? DISCARD : HUNT;
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      tx_byte_type x;
      if (reset) begin
         my_addr = ADDR_RESET; my_reg = REG_RESET; my_skip = SKIP_RESET;
         ph = HUNT; nbytes = 0; crc = 16'hFFFF; slot = 0; skip_left = 0;
         foreach (window[i]) window[i] = '0;
         tx_queue.delete();
         fail_count = 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
               REG_ADDR:   my_addr = pwdata[7:0];
               REG_TARGET: my_reg  = pwdata[7:0];
               REG_SKIP:   my_skip = pwdata[3:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) take_item(req_cmd, req_bus_byte, req_sample);
         if (rsp_valid && !rsp_stall) begin
            if (tx_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected byte %h last %b err %b", rsp_out_byte,
                           rsp_last_byte, rsp_is_error_text);
            end else begin
               x = tx_queue.pop_front();
               if (x.data !== rsp_out_byte || x.last !== rsp_last_byte ||
                   x.err !== rsp_is_error_text) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("byte mismatch: exp %h/%b/%b got %h/%b/%b", x.data, x.last,
                              x.err, rsp_out_byte, rsp_last_byte, rsp_is_error_text);
               end
            end
         end
      end
      pending = tx_queue.size();
   end
endmodule

// File: tb/modbus_rtu_median_sensor_responder_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_median_sensor_responder_unit_tb
// Drives samples, request frames, wrong addresses and register writes into
// the Modbus responder with random gaps and stalls; the checker judges.
// ----------------------------------------------------------------------------
module modbus_rtu_median_sensor_responder_unit_tb;
   import mrm_pkg::*;

   logic        clock, reset;
   logic        req_valid, req_stall, req_cmd;
   logic [7:0]  req_bus_byte;
   logic [15:0] req_sample;
   logic        rsp_valid, rsp_stall, rsp_last_byte, rsp_is_error_text;
   logic [7:0]  rsp_out_byte;
   logic        psel, penable, pwrite, pready;
   logic [3:0]  paddr;
   logic [31:0] pwdata, prdata;
   int          fail_count, pending, idle_cycles, rsp_gap;
   logic [7:0]  cur_addr, cur_reg;
   bit          hold_rsp;

   modbus_rtu_median_sensor_responder_unit dut (.*);

   modbus_rtu_median_sensor_responder_unit_checker chk (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // valid stays up after acceptance; the next gap or a drain drops it
   task automatic send(input logic c, input logic [7:0] b, input logic [15:0] s);
      repeat ($urandom_range(0, 14)) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1; req_cmd <= c; req_bus_byte <= b; req_sample <= s;
      do @(posedge clock); while (req_stall);
   endtask

   function automatic logic [15:0] crc16(input logic [15:0] c, input logic [7:0] b);
      c = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      return c;
   endfunction

   // corrupt: 0 good, 1 bad crc, 2 wrong register
   task automatic send_frame(input int corrupt, input bit with_samples);
      logic [7:0]  f[8];
      logic [15:0] c;
      f[0] = cur_addr; f[1] = FUNC_READ; f[2] = $urandom; f[3] = cur_reg;
      f[4] = $urandom; f[5] = $urandom;
      if (corrupt == 2) f[3] = cur_reg ^ (8'h1 << $urandom_range(0, 7));
      c = 16'hFFFF;
      for (int i = 0; i < 6; i++) c = crc16(c, f[i]);
      f[6] = c[7:0]; f[7] = c[15:8];
      if (corrupt == 1) f[6 + $urandom_range(0, 1)] ^= 8'h1 << $urandom_range(0, 7);
      for (int i = 0; i < 8; i++) begin
         if (with_samples && $urandom_range(0, 5) == 0) send(1, $urandom, $urandom);
         send(0, f[i], $urandom);
      end
   endtask

   task automatic wait_drain();
      req_valid <= 0;
      while (pending != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] v);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      @(posedge clock);
      if (idx == REG_ADDR) cur_addr = v[7:0];
      if (idx == REG_TARGET) cur_reg = v[7:0];
   endtask

   task automatic wrong_addr();
      logic [7:0] b;
      do b = $urandom; while (b == cur_addr);
      send(0, b, $urandom);
   endtask

   // receiver: a random wait before each item, plus one long hold-off on request
   initial begin
      rsp_stall = 1;
      @(negedge reset);
      forever begin
         rsp_gap = $urandom_range(0, 14);
         if (hold_rsp) begin
            rsp_gap = 400;
            hold_rsp = 0;
         end
         if (rsp_gap > 0) begin
            rsp_stall <= 1;
            repeat (rsp_gap) @(posedge clock);
         end
         rsp_stall <= 0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   // watchdog: cycles without any accepted item
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (psel && penable)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      reset = 1; req_valid = 0; req_cmd = 0; req_bus_byte = 0; req_sample = 0;
      psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
      hold_rsp = 0;
      cur_addr = ADDR_RESET; cur_reg = REG_RESET;
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: zero window median, extremes, each failure path
      send_frame(0, 0);
      send(1, 8'h00, 16'hFFFF); send(1, 8'hFF, 16'h0000);
      for (int i = 0; i < 8; i++) send(1, 8'h00, 16'hFFFF);
      send_frame(0, 0);
      send_frame(1, 0);
      send_frame(2, 0);
      wrong_addr();
      for (int i = 0; i < 7; i++) send(0, cur_addr, 0);
      send(1, 0, 16'h1234);
      wait_drain();
      csr_write(REG_SKIP, 0);
      csr_write(REG_ADDR, 8'hFF);
      csr_write(REG_TARGET, 8'h00);
      send(0, 8'h00, 0);
      send_frame(0, 1);
      wait_drain();
      csr_write(REG_ADDR, 8'h00);
      csr_write(REG_TARGET, 8'hFF);
      csr_write(REG_SKIP, 15);
      send(0, 8'hFF, 0);
      for (int i = 0; i < 15; i++) send(0, $urandom, 0);
      send_frame(0, 1);
      wait_drain();
      // long receiver hold-off with the sender pushing on
      hold_rsp = 1;
      for (int i = 0; i < 3; i++) send_frame(0, 0);
      wait_drain();
      // random phases with varied settings
      for (int ph = 0; ph < 3; ph++) begin
         csr_write(REG_ADDR, $urandom);
         csr_write(REG_TARGET, $urandom);
         csr_write(REG_SKIP, $urandom_range(0, 15));
         for (int n = 0; n < 5; n++) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: send_frame(0, 1);
               4: send_frame($urandom_range(1, 2), 1);
               5: wrong_addr();
               6: send(0, $urandom, $urandom);
               default: repeat ($urandom_range(1, 4)) send(1, $urandom, $urandom);
            endcase
         end
         // resynchronize: flush any pending discard then partial frame
         for (int i = 0; i < 16; i++) send(0, cur_addr, 0);
         send_frame(0, 0);
         wait_drain();
      end
      wait_drain();
      if (fail_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule
